// ----- design/itoa_pkg.sv -----
package itoa_pkg;

  localparam int DATA_W          = 32;
  localparam int RADIX_W         = 6;
  localparam int STEP_W          = $clog2(DATA_W);
  localparam int DIGIT_SLOTS_DEF = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_SIGN,
    ST_READ,
    ST_SEND
  } state_t;

  function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [7:0] d8;
    d8 = {{(8-RADIX_W){1'b0}}, d};
    if (d < RADIX_DEC) begin
      return CHAR_ZERO + d8;
    end
    return CHAR_A + (d8 - {{(8-RADIX_W){1'b0}}, RADIX_DEC});
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

endpackage

// ----- design/itoa_in_if.sv -----
interface itoa_in_if;
  logic                          valid;
  logic                          ready;
  logic [itoa_pkg::DATA_W-1:0]   value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- design/itoa_out_if.sv -----
interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- design/itoa_div.sv -----
// Restoring divider, one quotient bit per cycle.
module itoa_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [itoa_pkg::DATA_W-1:0]    dividend,
  input  logic [itoa_pkg::RADIX_W-1:0]   divisor,
  output logic                           done,
  output logic [itoa_pkg::DATA_W-1:0]    quotient,
  output logic [itoa_pkg::RADIX_W-1:0]   remainder
);

  logic                           busy_r;
  logic                           done_r;
  logic [itoa_pkg::STEP_W-1:0]    cnt_r;
  logic [itoa_pkg::DATA_W-1:0]    quo_r;
  logic [itoa_pkg::RADIX_W-1:0]   rem_r;
  logic [itoa_pkg::RADIX_W-1:0]   div_r;

  logic [itoa_pkg::RADIX_W:0]     trial;
  logic [itoa_pkg::RADIX_W:0]     diff;
  logic                           fits;

  assign trial = {rem_r, quo_r[itoa_pkg::DATA_W-1]};
  assign fits  = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == itoa_pkg::STEP_W'(itoa_pkg::DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[itoa_pkg::DATA_W-2:0], fits};
      rem_r <= fits ? diff[itoa_pkg::RADIX_W-1:0] : trial[itoa_pkg::RADIX_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- design/integer_to_base_ascii_top.sv -----
// Integer to ASCII text converter in a programmable base.
// in_ch: one signed 32-bit value per item. out_ch: one ASCII character per
// item, most significant first, last set on the final character. A leading
// '-' is sent only for negative values in base 10; other bases print the
// magnitude. Zero gives "0".
// cfg_we/cfg_wdata write the radix (reset 10); values below 2 act as 2 and
// values above 36 act as 36. Write it only while the block is idle.
// Sequence: digits come from one shared bit-serial divider, 32 steps per
// digit, and each digit goes into the digit store on hand-off. After the
// last digit a minus sign, if any, is loaded first; then each character
// takes a store read, then a load of the output register. in_ch.ready is
// high only between items. The output register holds the last character
// while the next value is already being converted.
// A stalled receiver holds the block in its sign or send phase; nothing is lost.
// Reset (rst_n low, synchronous) empties the output register, idles the
// sequencer and sets the radix to 10. The digit store needs no clearing.
module integer_to_base_ascii_top #(
  parameter int DIGIT_SLOTS = itoa_pkg::DIGIT_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  itoa_in_if.sink                       in_ch,
  itoa_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [itoa_pkg::RADIX_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
  localparam int IDX_W = $clog2(DIGIT_SLOTS);

  itoa_pkg::state_t               state_r, state_nxt;
  logic [itoa_pkg::RADIX_W-1:0]   radix_r;
  logic [itoa_pkg::RADIX_W-1:0]   base_r, base_nxt;
  logic [itoa_pkg::DATA_W-1:0]    mag_r, mag_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic                           minus_r, minus_nxt;

  logic                           out_valid_r;
  logic [7:0]                     out_char_r;
  logic                           out_last_r;
  logic                           out_load;
  logic [7:0]                     out_char_nxt;
  logic                           out_last_nxt;
  logic                           slot_free;

  logic                           div_start;
  logic                           div_done;
  logic [itoa_pkg::DATA_W-1:0]    div_quo;
  logic [itoa_pkg::RADIX_W-1:0]   div_rem;

  logic [itoa_pkg::RADIX_W-1:0]   digit_mem [DIGIT_SLOTS];
  logic [itoa_pkg::RADIX_W-1:0]   rd_data_r;
  logic                           mem_we;
  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;
  logic [CNT_W-1:0]               count_dec;

  logic [itoa_pkg::RADIX_W-1:0]   in_base;
  logic                           in_neg;

  itoa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mag_r),
    .divisor   (base_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_base   = itoa_pkg::clamp_radix(radix_r);
  assign in_neg    = in_ch.value[itoa_pkg::DATA_W-1];
  assign count_dec = count_r - 1'b1;
  assign rd_addr   = count_dec[IDX_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    mag_nxt      = mag_r;
    count_nxt    = count_r;
    minus_nxt    = minus_r;
    in_ch.ready  = 1'b0;
    div_start    = 1'b0;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    out_char_nxt = itoa_pkg::CHAR_MINUS;
    out_last_nxt = 1'b0;
    case (state_r)
      itoa_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          base_nxt  = in_base;
          mag_nxt   = in_neg ? (~in_ch.value + 1'b1) : in_ch.value;
          minus_nxt = in_neg && (in_base == itoa_pkg::RADIX_DEC);
          count_nxt = '0;
          state_nxt = itoa_pkg::ST_START;
        end
      end
      itoa_pkg::ST_START: begin
        div_start = 1'b1;
        state_nxt = itoa_pkg::ST_WAIT;
      end
      itoa_pkg::ST_WAIT: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mag_nxt   = div_quo;
          count_nxt = count_r + 1'b1;
          if (div_quo != '0 && count_r != CNT_W'(DIGIT_SLOTS - 1)) begin
            state_nxt = itoa_pkg::ST_START;
          end else if (minus_r) begin
            state_nxt = itoa_pkg::ST_SIGN;
          end else begin
            state_nxt = itoa_pkg::ST_READ;
          end
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_char_nxt = itoa_pkg::CHAR_MINUS;
          out_last_nxt = 1'b0;
          minus_nxt    = 1'b0;
          state_nxt    = itoa_pkg::ST_READ;
        end
      end
      itoa_pkg::ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = itoa_pkg::ST_SEND;
      end
      itoa_pkg::ST_SEND: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_char_nxt = itoa_pkg::digit_char(rd_data_r);
          out_last_nxt = (count_r == CNT_W'(1));
          count_nxt    = count_dec;
          state_nxt    = (count_r == CNT_W'(1)) ? itoa_pkg::ST_IDLE : itoa_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      radix_r     <= itoa_pkg::RADIX_RESET;
      mag_r       <= '0;
      count_r     <= '0;
      minus_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mag_r   <= mag_nxt;
      count_r <= count_nxt;
      minus_r <= minus_nxt;
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[count_r[IDX_W-1:0]] <= div_rem;
    end
    if (rd_en) begin
      rd_data_r <= digit_mem[rd_addr];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == itoa_pkg::ST_WAIT)
    else $error("divider result outside wait state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DIGIT_SLOTS))
    else $error("digit count beyond store depth");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == itoa_pkg::ST_START && count_r == '0))
    else $error("accepted item did not start conversion");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt) |=> (state_r == itoa_pkg::ST_IDLE && count_r == '0))
    else $error("final character did not return to idle");

endmodule

// ----- test/integer_to_base_ascii_top_tb.sv -----
`timescale 1ns / 100ps

module integer_to_base_ascii_top_tb;

  localparam int SLOTS       = itoa_pkg::DIGIT_SLOTS_DEF;
  localparam int RAND_ITEMS  = 400;
  localparam int CALM_ITEMS  = 60;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 2500;
  localparam int TAIL_CYCLES = 80;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [itoa_pkg::RADIX_W-1:0] cfg_wdata;

  itoa_in_if  in_ch();
  itoa_out_if out_ch();

  integer_to_base_ascii_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  char_item_t                   expected_chars_q [$];
  string                        typed_text_q [$];
  logic [itoa_pkg::RADIX_W-1:0] dir_radix_q [$];
  logic [31:0]                  dir_value_q [$];
  string                        dir_text_q [$];
  logic [itoa_pkg::RADIX_W-1:0] radix_seen = itoa_pkg::RADIX_RESET;
  int                           errors = 0;
  int                           items_in = 0;
  bit                           calm = 1'b0;

  always #4 clk = ~clk;

  initial begin
    #30_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("%0t mismatch on %s: got %02h, expected %02h", $time, what, got, want);
    end
  endtask

  function automatic void predict_text(input logic [31:0] v,
                                       input logic [itoa_pkg::RADIX_W-1:0] r);
    logic [5:0]  digits [SLOTS];
    logic [31:0] mag;
    logic [31:0] base;
    int          n;
    base = 32'((r < itoa_pkg::RADIX_MIN) ? itoa_pkg::RADIX_MIN :
               (r > itoa_pkg::RADIX_MAX) ? itoa_pkg::RADIX_MAX : r);
    if (v == '0) begin
      expected_chars_q.push_back({itoa_pkg::CHAR_ZERO, 1'b1});
      return;
    end
    mag = v[31] ? (32'd0 - v) : v;
    n = 0;
    while (mag != 0 && n < SLOTS) begin
      digits[n] = 6'(mag % base);
      mag = mag / base;
      n++;
    end
    if (v[31] && base == 32'(itoa_pkg::RADIX_DEC)) begin
      expected_chars_q.push_back({itoa_pkg::CHAR_MINUS, 1'b0});
    end
    for (int i = n - 1; i >= 0; i--) begin
      expected_chars_q.push_back({(digits[i] < itoa_pkg::RADIX_DEC)
                                  ? itoa_pkg::CHAR_ZERO + 8'(digits[i])
                                  : itoa_pkg::CHAR_A + 8'(digits[i])
                                    - 8'(itoa_pkg::RADIX_DEC), i == 0});
    end
  endfunction

  task automatic add_row(input logic [itoa_pkg::RADIX_W-1:0] r, input logic [31:0] v,
                         input string text);
    dir_radix_q.push_back(r);
    dir_value_q.push_back(v);
    dir_text_q.push_back(text);
  endtask

  task automatic send_value(input logic [31:0] v, input string text);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    typed_text_q.push_back(text);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic write_radix(input logic [itoa_pkg::RADIX_W-1:0] r);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_chars_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // scoreboard: expectations are queued at input acceptance
  always @(posedge clk) begin : monitor
    char_item_t want;
    string      text;
    if (!rst_n) begin
      radix_seen = itoa_pkg::RADIX_RESET;
    end else begin
      if (cfg_we) begin
        radix_seen = cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        items_in++;
        text = typed_text_q.pop_front();
        if (text.len() != 0) begin
          for (int i = 0; i < text.len(); i++) begin
            expected_chars_q.push_back({text[i], i == text.len() - 1});
          end
        end else begin
          predict_text(in_ch.value, radix_seen);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars_q.size() == 0) begin
          report_mismatch("unexpected item", out_ch.character, 8'h00);
        end else begin
          want = expected_chars_q.pop_front();
          if (out_ch.character !== want.ch) begin
            report_mismatch("character", out_ch.character, want.ch);
          end
          if (out_ch.last !== want.last) begin
            report_mismatch("last", {7'd0, out_ch.last}, {7'd0, want.last});
          end
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off to back up the input
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!held && items_in >= HOLD_AT) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [itoa_pkg::RADIX_W-1:0] cur_radix;
    logic [itoa_pkg::RADIX_W-1:0] r;
    logic [31:0]                  v;
    logic [31:0]                  mag;
    logic [31:0]                  base;
    int                           kind;
    int                           phase_len;
    int                           sent;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    rst_n       <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    cur_radix = itoa_pkg::RADIX_RESET;

    add_row(itoa_pkg::RADIX_RESET, 32'd0, "0");
    add_row(6'd10, 32'h7FFF_FFFF, "2147483647");
    add_row(6'd10, 32'h8000_0000, "-2147483648");
    add_row(6'd10, 32'hFFFF_FFFF, "-1");
    add_row(6'd10, 32'd1, "1");
    add_row(6'd10, 32'd123456789, "");
    add_row(6'd10, -32'sd10, "-10");
    add_row(6'd2, 32'h8000_0000, "");
    add_row(6'd2, 32'hFFFF_FFFF, "1");
    add_row(6'd2, 32'h7FFF_FFFF, "");
    add_row(6'd2, 32'd0, "0");
    add_row(6'd0, 32'd5, "101");
    add_row(6'd1, -32'sd6, "110");
    add_row(6'd16, 32'h8000_0000, "80000000");
    add_row(6'd16, 32'hDEAD_BEEF, "");
    add_row(6'd16, 32'd255, "FF");
    add_row(6'd36, 32'd35, "Z");
    add_row(6'd36, 32'h7FFF_FFFF, "");
    add_row(6'd36, 32'h8000_0000, "");
    add_row(6'd37, 32'd35, "Z");
    add_row(6'd63, 32'd36, "10");
    add_row(6'd63, -32'sd35, "Z");
    add_row(6'd8, -32'sd8, "10");
    add_row(6'd10, 32'd0, "0");

    for (int i = 0; i < dir_value_q.size(); i++) begin
      if (dir_radix_q[i] != cur_radix) begin
        write_radix(dir_radix_q[i]);
        cur_radix = dir_radix_q[i];
      end
      send_value(dir_value_q[i], dir_text_q[i]);
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      kind = $urandom_range(0, 5);
      case (kind)
        0:       r = 6'($urandom_range(0, 63));
        1:       r = itoa_pkg::RADIX_MIN;
        2:       r = itoa_pkg::RADIX_MAX;
        3:       r = itoa_pkg::RADIX_DEC;
        default: r = 6'($urandom_range(2, 36));
      endcase
      write_radix(r);
      base = 32'((r < itoa_pkg::RADIX_MIN) ? itoa_pkg::RADIX_MIN :
                 (r > itoa_pkg::RADIX_MAX) ? itoa_pkg::RADIX_MAX : r);
      phase_len = $urandom_range(20, 50);
      for (int k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
        calm = (sent >= RAND_ITEMS - CALM_ITEMS);
        kind = $urandom_range(0, 19);
        if (kind < 6) begin
          v = $urandom;
        end else if (kind < 13) begin
          v = 32'($urandom_range(0, 2000)) - 32'd1000;
        end else if (kind < 18) begin
          mag = 32'd1;
          repeat ($urandom_range(1, 8)) mag = mag * base;
          mag = mag + 32'($urandom_range(0, 2)) - 32'd1;
          v = $urandom_range(0, 1) ? 32'd0 - mag : mag;
        end else begin
          case ($urandom_range(0, 3))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = '0;
            default: v = '1;
          endcase
        end
        send_value(v, "");
        sent++;
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_chars_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_chars_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
